FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the point-to-segment distance RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with synchronous reset masking.
`define PSD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that is also evaluated while reset is high.
`define PSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/psd_pkg.sv
// Shared types and constants for the point-to-segment distance pipeline.
// No dependencies; used by every module of the block by scoped name.
package psd_pkg;

   localparam int T_FRAC     = 16;   // fraction bits of the projection parameter
   localparam int T_BITS     = 17;   // one integer bit so that 1.0 is exact
   localparam int GUARD_BITS = 26;   // guarded error component width
   localparam int HALF_BITS  = 13;   // half of a guarded component for squaring
   localparam int SQ_BITS    = 54;   // radicand width, padded to an even count
   localparam int ROOT_BITS  = 27;   // square root width
   localparam int DIST_BITS  = 18;
   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
   localparam logic [DIST_BITS-1:0] NEAR_RESET = 18'd320;

   typedef enum logic [1:0] {
      TSEL_ZERO = 2'd0,
      TSEL_ONE  = 2'd1,
      TSEL_DIV  = 2'd2
   } tsel_type;

endpackage

FILE: hw/rtl/psd_front.sv
// Front end: coordinate differences, squared length and dot product, t selection.
// Depends on psd_pkg.
module psd_front #(
   parameter int CB = 13
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic signed [CB-1:0]         qx,
   input  logic signed [CB-1:0]         qy,
   input  logic signed [CB-1:0]         sx,
   input  logic signed [CB-1:0]         sy,
   input  logic signed [CB-1:0]         ex,
   input  logic signed [CB-1:0]         ey,
   output logic                         out_valid,
   output logic [2*(CB+1)-1:0]          len2,
   output logic [2*(CB+1)-1:0]          rem,
   output psd_pkg::tsel_type            tsel,
   output logic [4*(CB+1):0]            side
);

   localparam int DW = CB + 1;
   localparam int PW = 2 * DW;

   logic                 v1_ff, v2_ff, v3_ff;
   logic signed [DW-1:0] dx1_ff, dy1_ff, px1_ff, py1_ff;
   logic signed [DW-1:0] dx2_ff, dy2_ff, px2_ff, py2_ff;
   logic signed [PW-1:0] xx_ff, yy_ff, xd_ff, yd_ff;
   logic signed [PW-1:0] xx_in, yy_in, xd_in, yd_in;
   logic [PW-1:0]        len_in, len_ff, rem_in, rem_ff;
   logic signed [PW:0]   dot;
   logic                 degen;
   psd_pkg::tsel_type    tsel_in, tsel_ff;
   logic [4*DW:0]        side_in, side_ff;

   always_comb begin
      xx_in = dx1_ff * dx1_ff;
      yy_in = dy1_ff * dy1_ff;
      xd_in = px1_ff * dx1_ff;
      yd_in = py1_ff * dy1_ff;
   end

   always_comb begin
      len_in = PW'(xx_ff) + PW'(yy_ff);
      dot    = (PW+1)'(xd_ff) + (PW+1)'(yd_ff);
      degen  = (len_in == '0);
      rem_in = '0;
      if (degen || dot <= 0) begin
         tsel_in = psd_pkg::TSEL_ZERO;
      end else if (dot >= $signed({1'b0, len_in})) begin
         tsel_in = psd_pkg::TSEL_ONE;
      end else begin
         tsel_in = psd_pkg::TSEL_DIV;
         rem_in  = dot[PW-1:0];
      end
      side_in = {degen, px2_ff, py2_ff, dx2_ff, dy2_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (en) begin
         dx1_ff  <= DW'(ex) - DW'(sx);
         dy1_ff  <= DW'(ey) - DW'(sy);
         px1_ff  <= DW'(qx) - DW'(sx);
         py1_ff  <= DW'(qy) - DW'(sy);
         dx2_ff  <= dx1_ff;
         dy2_ff  <= dy1_ff;
         px2_ff  <= px1_ff;
         py2_ff  <= py1_ff;
         xx_ff   <= xx_in;
         yy_ff   <= yy_in;
         xd_ff   <= xd_in;
         yd_ff   <= yd_in;
         len_ff  <= len_in;
         rem_ff  <= rem_in;
         tsel_ff <= tsel_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = v3_ff;
   assign len2      = len_ff;
   assign rem       = rem_ff;
   assign tsel      = tsel_ff;
   assign side      = side_ff;

endmodule

FILE: hw/rtl/psd_div.sv
// Pipelined restoring divider: one quotient bit of t per register stage.
// Depends on psd_pkg.
module psd_div #(
   parameter int LW     = 28,
   parameter int SIDE_W = 57
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [LW-1:0]                 len2,
   input  logic [LW-1:0]                 rem,
   input  psd_pkg::tsel_type             tsel,
   input  logic [SIDE_W-1:0]             side,
   output logic                          out_valid,
   output logic [psd_pkg::T_FRAC-1:0]    quot,
   output psd_pkg::tsel_type             out_tsel,
   output logic [SIDE_W-1:0]             out_side
);

   localparam int QB = psd_pkg::T_FRAC;

   logic              valid_ff [QB];
   logic [LW-1:0]     rem_ff   [QB];
   logic [LW-1:0]     len_ff   [QB];
   logic [QB-1:0]     q_ff     [QB];
   psd_pkg::tsel_type tsel_ff  [QB];
   logic [SIDE_W-1:0] side_ff  [QB];

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic              v_src;
      logic [LW-1:0]     r_src, l_src, rem_in;
      logic [QB-1:0]     q_src, q_in;
      psd_pkg::tsel_type t_src;
      logic [SIDE_W-1:0] s_src;
      logic [LW:0]       r2, diff;
      logic              ge;

      if (k == 0) begin : g_first
         assign v_src = in_valid;
         assign r_src = rem;
         assign l_src = len2;
         assign q_src = '0;
         assign t_src = tsel;
         assign s_src = side;
      end else begin : g_next
         assign v_src = valid_ff[k-1];
         assign r_src = rem_ff[k-1];
         assign l_src = len_ff[k-1];
         assign q_src = q_ff[k-1];
         assign t_src = tsel_ff[k-1];
         assign s_src = side_ff[k-1];
      end

      always_comb begin
         r2     = {r_src, 1'b0};
         diff   = r2 - {1'b0, l_src};
         ge     = (r2 >= {1'b0, l_src});
         rem_in = ge ? diff[LW-1:0] : r2[LW-1:0];
         q_in   = {q_src[QB-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= v_src;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            len_ff[k]  <= l_src;
            q_ff[k]    <= q_in;
            tsel_ff[k] <= t_src;
            side_ff[k] <= s_src;
         end
      end
   end

   assign out_valid = valid_ff[QB-1];
   assign quot      = q_ff[QB-1];
   assign out_tsel  = tsel_ff[QB-1];
   assign out_side  = side_ff[QB-1];

endmodule

FILE: hw/rtl/psd_err.sv
// Error vector, magnitude guard and sum of squares feeding the square root.
// Depends on psd_pkg.
module psd_err #(
   parameter int CB = 13,
   parameter int FB = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [psd_pkg::T_FRAC-1:0]    quot,
   input  psd_pkg::tsel_type             tsel,
   input  logic [4*(CB+1):0]             side,
   output logic                          out_valid,
   output logic [psd_pkg::SQ_BITS-1:0]   sumsq,
   output logic                          sat,
   output logic                          degen
);

   localparam int DW = CB + 1;
   localparam int EW = DW + 18;
   localparam int GB = psd_pkg::GUARD_BITS;
   localparam int HB = psd_pkg::HALF_BITS;
   localparam int SB = psd_pkg::SQ_BITS;

   logic signed [DW-1:0] px, py, dx, dy;
   logic [psd_pkg::T_BITS-1:0] t;
   logic signed [EW-1:0] tdx_in, tdy_in, tdx_ff, tdy_ff;
   logic signed [DW-1:0] pxa_ff, pya_ff;
   logic signed [EW-1:0] errx, erry;
   logic [EW-1:0]        magx, magy, gx, gy;
   logic [GB-1:0]        gx_ff, gy_ff;
   logic [2*HB-1:0]      xhh_ff, xhl_ff, xll_ff, yhh_ff, yhl_ff, yll_ff;
   logic [SB-1:0]        sum_in, sum_ff;
   logic                 va_ff, vb_ff, vc_ff, vd_ff;
   logic                 da_ff, db_ff, dc_ff, dd_ff;
   logic                 sat_in, sb_ff, sc_ff, sd_ff;

   always_comb begin
      px = side[4*DW-1:3*DW];
      py = side[3*DW-1:2*DW];
      dx = side[2*DW-1:DW];
      dy = side[DW-1:0];
      case (tsel)
         psd_pkg::TSEL_ONE: t = psd_pkg::T_BITS'(1) << psd_pkg::T_FRAC;
         psd_pkg::TSEL_DIV: t = {1'b0, quot};
         default:           t = '0;
      endcase
      tdx_in = $signed({1'b0, t}) * dx;
      tdy_in = $signed({1'b0, t}) * dy;
   end

   // Magnitude of each error component, trimmed to the output fraction
   // plus eight guard bits, with an overflow flag for huge distances.
   always_comb begin
      errx   = (EW'(pxa_ff) <<< psd_pkg::T_FRAC) - tdx_ff;
      erry   = (EW'(pya_ff) <<< psd_pkg::T_FRAC) - tdy_ff;
      magx   = errx[EW-1] ? EW'(-errx) : EW'(errx);
      magy   = erry[EW-1] ? EW'(-erry) : EW'(erry);
      gx     = magx >> (8 - FB);
      gy     = magy >> (8 - FB);
      sat_in = (|gx[EW-1:GB]) || (|gy[EW-1:GB]);
   end

   always_comb begin
      sum_in = ((SB'(xhh_ff) + SB'(yhh_ff)) << (2 * HB))
             + ((SB'(xhl_ff) + SB'(yhl_ff)) << (HB + 1))
             + SB'(xll_ff) + SB'(yll_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
      if (en) begin
         tdx_ff <= tdx_in;
         tdy_ff <= tdy_in;
         pxa_ff <= px;
         pya_ff <= py;
         da_ff  <= side[4*DW];
         gx_ff  <= gx[GB-1:0];
         gy_ff  <= gy[GB-1:0];
         sb_ff  <= sat_in;
         db_ff  <= da_ff;
         xhh_ff <= gx_ff[GB-1:HB] * gx_ff[GB-1:HB];
         xhl_ff <= gx_ff[GB-1:HB] * gx_ff[HB-1:0];
         xll_ff <= gx_ff[HB-1:0] * gx_ff[HB-1:0];
         yhh_ff <= gy_ff[GB-1:HB] * gy_ff[GB-1:HB];
         yhl_ff <= gy_ff[GB-1:HB] * gy_ff[HB-1:0];
         yll_ff <= gy_ff[HB-1:0] * gy_ff[HB-1:0];
         sc_ff  <= sb_ff;
         dc_ff  <= db_ff;
         sum_ff <= sum_in;
         sd_ff  <= sc_ff;
         dd_ff  <= dc_ff;
      end
   end

   assign out_valid = vd_ff;
   assign sumsq     = sum_ff;
   assign sat       = sd_ff;
   assign degen     = dd_ff;

endmodule

FILE: hw/rtl/psd_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on psd_pkg.
module psd_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [psd_pkg::SQ_BITS-1:0]    radicand,
   input  logic                           sat,
   input  logic                           degen,
   output logic                           out_valid,
   output logic [psd_pkg::ROOT_BITS-1:0]  root,
   output logic                           out_sat,
   output logic                           out_degen
);

   localparam int RB = psd_pkg::ROOT_BITS;
   localparam int SB = psd_pkg::SQ_BITS;
   localparam int RW = RB + 1;

   logic          valid_ff [RB];
   logic [RW-1:0] rem_ff   [RB];
   logic [RB-1:0] root_ff  [RB];
   logic [SB-1:0] s_ff     [RB];
   logic          sat_ff   [RB];
   logic          degen_ff [RB];

   for (genvar k = 0; k < RB; k++) begin : g_stage
      logic          v_src, sat_src, dg_src;
      logic [RW-1:0] r_src, rem_in;
      logic [RB-1:0] root_src, root_in;
      logic [SB-1:0] s_src;
      logic [RW+1:0] cur, trial;
      logic          ge;

      if (k == 0) begin : g_first
         assign v_src    = in_valid;
         assign r_src    = '0;
         assign root_src = '0;
         assign s_src    = radicand;
         assign sat_src  = sat;
         assign dg_src   = degen;
      end else begin : g_next
         assign v_src    = valid_ff[k-1];
         assign r_src    = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign s_src    = s_ff[k-1];
         assign sat_src  = sat_ff[k-1];
         assign dg_src   = degen_ff[k-1];
      end

      always_comb begin
         cur     = {r_src, s_src[SB-1:SB-2]};
         trial   = {1'b0, root_src, 2'b01};
         ge      = (cur >= trial);
         rem_in  = ge ? RW'(cur - trial) : RW'(cur);
         root_in = {root_src[RB-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= v_src;
         end
         if (en) begin
            rem_ff[k]   <= rem_in;
            root_ff[k]  <= root_in;
            s_ff[k]     <= {s_src[SB-3:0], 2'b00};
            sat_ff[k]   <= sat_src;
            degen_ff[k] <= dg_src;
         end
      end
   end

   assign out_valid = valid_ff[RB-1];
   assign root      = root_ff[RB-1];
   assign out_sat   = sat_ff[RB-1];
   assign out_degen = degen_ff[RB-1];

endmodule

FILE: hw/rtl/point_segment_distance.sv
// Top level of the point-to-segment distance pipeline.
// Depends on psd_pkg, psd_front, psd_div, psd_err, psd_sqrt and assert_macros.svh.

// A query point and a segment arrive together as one transaction, signed pixel
// coordinates; one result transaction comes back per request, in order, with the
// distance to the segment in 1/16 pixel (truncated), a near flag against the
// csr threshold (reset 320, twenty pixels) and a zero-length flag. The block
// takes one request every clock cycle while req_stall is low. From request
// acceptance to the result on rsp_valid, a transaction passes through 3 front-end
// stages (differences, products, clamp of the projection), 16 divider stages (one
// bit of the projection parameter each), 4 error and sum-of-squares stages, 27
// square-root stages (one root bit each), a final scaling stage and the output
// register. A two-entry output buffer lets a request in while a finished result
// waits; req_stall rises only once both entries are full. The threshold is sampled
// as each result is formed, so write it only while no transactions are in flight.

`include "assert_macros.svh"

module point_segment_distance #(
   parameter int COORD_BITS = 13,
   parameter int FRAC_BITS  = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_BITS-1:0]          req_query_x,
   input  logic signed [COORD_BITS-1:0]          req_query_y,
   input  logic signed [COORD_BITS-1:0]          req_seg_start_x,
   input  logic signed [COORD_BITS-1:0]          req_seg_start_y,
   input  logic signed [COORD_BITS-1:0]          req_seg_end_x,
   input  logic signed [COORD_BITS-1:0]          req_seg_end_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [psd_pkg::DIST_BITS-1:0]         rsp_distance,
   output logic                                  rsp_is_near,
   output logic                                  rsp_degenerate,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [psd_pkg::DIST_BITS-1:0]         csr_near_threshold
);

   localparam int DW     = COORD_BITS + 1;
   localparam int LW     = 2 * DW;
   localparam int SIDE_W = 4 * DW + 1;
   localparam int DB     = psd_pkg::DIST_BITS;
   localparam int RB     = psd_pkg::ROOT_BITS;

   // The whole pipeline advances together; it halts only while the skid
   // entry is occupied, which happens when the consumer stalls a waiting result.
   logic en;

   logic                       f_valid;
   logic [LW-1:0]              f_len2, f_rem;
   psd_pkg::tsel_type          f_tsel;
   logic [SIDE_W-1:0]          f_side;

   logic                       d_valid;
   logic [psd_pkg::T_FRAC-1:0] d_quot;
   psd_pkg::tsel_type          d_tsel;
   logic [SIDE_W-1:0]          d_side;

   logic                       e_valid, e_sat, e_degen;
   logic [psd_pkg::SQ_BITS-1:0] e_sumsq;

   logic                       s_valid, s_sat, s_degen;
   logic [RB-1:0]              s_root;

   logic [DB-1:0] thresh_ff;

   // Final stage: scale the root down to 1/16 pixel and saturate.
   logic [RB-9:0] dist_wide;
   logic [DB-1:0] dist_in;
   logic          near_in;
   logic          fin_valid_ff, fin_near_ff, fin_degen_ff;
   logic [DB-1:0] fin_dist_ff;

   // Output register and skid entry.
   logic          rsp_valid_ff, rsp_near_ff, rsp_degen_ff;
   logic [DB-1:0] rsp_dist_ff;
   logic          skid_valid_ff, skid_near_ff, skid_degen_ff;
   logic [DB-1:0] skid_dist_ff;
   logic          rsp_take;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign csr_ready = 1'b1;

   psd_front #(.CB(COORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .qx        (req_query_x),
      .qy        (req_query_y),
      .sx        (req_seg_start_x),
      .sy        (req_seg_start_y),
      .ex        (req_seg_end_x),
      .ey        (req_seg_end_y),
      .out_valid (f_valid),
      .len2      (f_len2),
      .rem       (f_rem),
      .tsel      (f_tsel),
      .side      (f_side)
   );

   psd_div #(.LW(LW), .SIDE_W(SIDE_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .len2      (f_len2),
      .rem       (f_rem),
      .tsel      (f_tsel),
      .side      (f_side),
      .out_valid (d_valid),
      .quot      (d_quot),
      .out_tsel  (d_tsel),
      .out_side  (d_side)
   );

   psd_err #(.CB(COORD_BITS), .FB(FRAC_BITS)) u_err (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .quot      (d_quot),
      .tsel      (d_tsel),
      .side      (d_side),
      .out_valid (e_valid),
      .sumsq     (e_sumsq),
      .sat       (e_sat),
      .degen     (e_degen)
   );

   psd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (e_valid),
      .radicand  (e_sumsq),
      .sat       (e_sat),
      .degen     (e_degen),
      .out_valid (s_valid),
      .root      (s_root),
      .out_sat   (s_sat),
      .out_degen (s_degen)
   );

   always_comb begin
      dist_wide = s_root[RB-1:8];
      if (s_sat || (dist_wide > (RB-8)'(psd_pkg::DIST_MAX))) begin
         dist_in = psd_pkg::DIST_MAX;
      end else begin
         dist_in = dist_wide[DB-1:0];
      end
      near_in = (dist_in < thresh_ff);
   end

   assign rsp_take = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= psd_pkg::NEAR_RESET;
      end else if (csr_valid && csr_ready) begin
         thresh_ff <= csr_near_threshold;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (en) begin
         fin_valid_ff <= s_valid;
      end
      if (en) begin
         fin_dist_ff  <= dist_in;
         fin_near_ff  <= near_in;
         fin_degen_ff <= s_degen;
      end
   end

   // The final stage result goes straight to the output register when that
   // register is empty or being emptied, and otherwise into the skid entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (fin_valid_ff) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_dist_ff  <= skid_dist_ff;
            rsp_near_ff  <= skid_near_ff;
            rsp_degen_ff <= skid_degen_ff;
         end
      end else if (fin_valid_ff) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_dist_ff  <= fin_dist_ff;
            rsp_near_ff  <= fin_near_ff;
            rsp_degen_ff <= fin_degen_ff;
         end else begin
            skid_dist_ff  <= fin_dist_ff;
            skid_near_ff  <= fin_near_ff;
            skid_degen_ff <= fin_degen_ff;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_distance   = rsp_dist_ff;
   assign rsp_is_near    = rsp_near_ff;
   assign rsp_degenerate = rsp_degen_ff;

   // The skid entry is only ever used behind an occupied output register.
   `PSD_ASSERT(a_skid_behind_rsp, clock, reset, skid_valid_ff |-> rsp_valid_ff, "skid entry valid with empty output register")

   // A finished result that meets a stalled output register must land in the skid entry.
   `PSD_ASSERT(a_skid_fill, clock, reset, (rsp_valid_ff && rsp_stall && fin_valid_ff && !skid_valid_ff) |=> skid_valid_ff, "stalled result was not captured in the skid entry")

   // Draining the skid entry keeps the output register loaded.
   `PSD_ASSERT(a_skid_drain, clock, reset, (skid_valid_ff && rsp_take) |=> (rsp_valid_ff && !skid_valid_ff), "skid entry did not drain into the output register")

endmodule
